// File: rtl/core/ecl_pkg.sv
// Package with the sizes, types and control codes shared by the capacity limiter modules.
package ecl_pkg;

  localparam int MAX_EXPERTS = 64;
  localparam int MAX_WORKERS = 64;
  localparam int COUNT_WIDTH = 32;

  localparam int EXP_W    = $clog2(MAX_EXPERTS);
  localparam int WRK_W    = $clog2(MAX_WORKERS);
  localparam int EXP_NUM_W = $clog2(MAX_EXPERTS + 1);
  localparam int WRK_NUM_W = $clog2(MAX_WORKERS + 1);

  localparam int AMOUNT_W = 32;
  localparam int INDEX_W  = 6;
  localparam int REG_W    = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_EXPERTS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORKERS_IN_USE = 2'd1;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_wr;   // write the capacity of the next expert
    logic prop_take; // capture a proposal amount
    logic calc;      // compute the grant and write back the capacity left
  } ecl_cmd_t;

endpackage

// File: rtl/core/ecl_ctrl.sv
// Controller state machine of the capacity limiter: accepts requests and sequences the datapath.
module ecl_ctrl
  import ecl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_mode,
  output logic     busy,
  output ecl_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd.load_wr   = 1'b0;
    cmd.prop_take = 1'b0;
    cmd.calc      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode) begin
            cmd.prop_take = 1'b1;
            state_nxt     = ST_CALC;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/ecl_dp.sv
// Datapath of the capacity limiter: capacity table, counters, grant arithmetic and result register.
module ecl_dp
  import ecl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  ecl_cmd_t             cmd,
  input  logic [AMOUNT_W-1:0]  in_amount,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata,
  output logic                 out_strobe,
  output logic [AMOUNT_W-1:0]  out_granted,
  output logic [INDEX_W-1:0]   out_expert_index,
  output logic [INDEX_W-1:0]   out_worker_index,
  output logic                 out_clipped,
  output logic                 out_last
);

  count_t mem [0:MAX_EXPERTS-1];
  count_t rd_data_r;
  count_t amount_r;

  logic [REG_W-1:0] experts_reg_r;
  logic [REG_W-1:0] workers_reg_r;
  logic [EXP_W-1:0] load_ptr_r;
  logic [EXP_W-1:0] exp_ptr_r;
  logic [WRK_W-1:0] wrk_ptr_r;

  logic [EXP_NUM_W-1:0] num_exp;
  logic [WRK_NUM_W-1:0] num_wrk;
  logic [EXP_W-1:0]     last_exp;
  logic [WRK_W-1:0]     last_wrk;
  logic                 exp_at_end;
  logic                 wrk_at_end;
  logic                 cfg_hit;

  logic   clip;
  count_t grant;
  count_t cap_nxt;

  logic                 strobe_r;
  logic [AMOUNT_W-1:0]  granted_r;
  logic [INDEX_W-1:0]   exp_idx_r;
  logic [INDEX_W-1:0]   wrk_idx_r;
  logic                 clipped_r;
  logic                 last_r;

  // Register values of zero act as one, values above the table size as the maximum.
  always_comb begin
    if (experts_reg_r == '0) begin
      num_exp = EXP_NUM_W'(1);
    end else if (experts_reg_r > REG_W'(MAX_EXPERTS)) begin
      num_exp = EXP_NUM_W'(MAX_EXPERTS);
    end else begin
      num_exp = EXP_NUM_W'(experts_reg_r);
    end
    if (workers_reg_r == '0) begin
      num_wrk = WRK_NUM_W'(1);
    end else if (workers_reg_r > REG_W'(MAX_WORKERS)) begin
      num_wrk = WRK_NUM_W'(MAX_WORKERS);
    end else begin
      num_wrk = WRK_NUM_W'(workers_reg_r);
    end
  end

  assign last_exp   = EXP_W'(num_exp - EXP_NUM_W'(1));
  assign last_wrk   = WRK_W'(num_wrk - WRK_NUM_W'(1));
  assign exp_at_end = (exp_ptr_r == last_exp);
  assign wrk_at_end = (wrk_ptr_r == last_wrk);
  assign cfg_hit    = cfg_we && ((cfg_index == REG_EXPERTS_IN_USE) ||
                                 (cfg_index == REG_WORKERS_IN_USE));

  assign clip    = (amount_r > rd_data_r);
  assign grant   = clip ? rd_data_r : amount_r;
  assign cap_nxt = rd_data_r - grant;

  // The table is read at the expert counter every cycle; loads and write-backs share one port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[exp_ptr_r];
    if (cmd.load_wr) begin
      mem[load_ptr_r] <= COUNT_WIDTH'(in_amount);
    end else if (cmd.calc) begin
      mem[exp_ptr_r] <= cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prop_take) begin
      amount_r <= COUNT_WIDTH'(in_amount);
    end
    granted_r <= AMOUNT_W'(grant);
    exp_idx_r <= INDEX_W'(exp_ptr_r);
    wrk_idx_r <= INDEX_W'(wrk_ptr_r);
    clipped_r <= clip;
    last_r    <= exp_at_end && wrk_at_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      experts_reg_r <= REG_W'(1);
      workers_reg_r <= REG_W'(1);
      load_ptr_r    <= '0;
      exp_ptr_r     <= '0;
      wrk_ptr_r     <= '0;
      strobe_r      <= 1'b0;
    end else begin
      strobe_r <= cmd.calc;
      if (cfg_hit) begin
        if (cfg_index == REG_EXPERTS_IN_USE) begin
          experts_reg_r <= cfg_wdata;
        end else begin
          workers_reg_r <= cfg_wdata;
        end
        load_ptr_r <= '0;
        exp_ptr_r  <= '0;
        wrk_ptr_r  <= '0;
      end else begin
        if (cmd.load_wr) begin
          load_ptr_r <= (load_ptr_r == last_exp) ? '0 : load_ptr_r + EXP_W'(1);
        end
        if (cmd.calc) begin
          if (exp_at_end) begin
            exp_ptr_r <= '0;
            wrk_ptr_r <= wrk_at_end ? '0 : wrk_ptr_r + WRK_W'(1);
          end else begin
            exp_ptr_r <= exp_ptr_r + EXP_W'(1);
          end
        end
      end
    end
  end

  assign out_strobe       = strobe_r;
  assign out_granted      = granted_r;
  assign out_expert_index = exp_idx_r;
  assign out_worker_index = wrk_idx_r;
  assign out_clipped      = clipped_r;
  assign out_last         = last_r;

endmodule

// File: rtl/core/expert_capacity_limiter.sv
// Top level of the per-expert token capacity limiter for a mixture-of-experts router.
//
//   Channel  Ports                                   Handshake
//   -------  --------------------------------------  ------------------------------
//   input    in_mode, in_amount                      start high while busy is low
//   result   out_granted, out_expert_index,          out_strobe high for one cycle
//            out_worker_index, out_clipped, out_last
//   config   cfg_index, cfg_wdata                    cfg_we high, no wait
//
// A load request writes the capacity table at the load counter, and busy stays low. A proposal
// request goes through the table's single registered read port: the entry is read at the accept
// edge and the grant is written back from the ST_CALC state that follows. Its result is registered
// onto the result ports at the same edge as that write-back, and the next
// request can already be accepted. Reset (rst_n, synchronous, active low) clears the counters
// and the registers to one expert and one worker; table contents are undefined until loaded.
// The receiver cannot stall, so every result is shown for exactly one cycle.
module expert_capacity_limiter
  import ecl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_mode,
  input  logic [AMOUNT_W-1:0]  in_amount,
  output logic                 out_strobe,
  output logic [AMOUNT_W-1:0]  out_granted,
  output logic [INDEX_W-1:0]   out_expert_index,
  output logic [INDEX_W-1:0]   out_worker_index,
  output logic                 out_clipped,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata
);

  // Commands from the state machine to the datapath.
  ecl_cmd_t cmd;

  // The controller decides per request whether it is a load or a proposal.
  ecl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .busy    (busy),
    .cmd     (cmd)
  );

  // The datapath holds the capacity table, the expert and worker counters, the
  // configuration registers and the result register.
  ecl_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_amount        (in_amount),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_strobe       (out_strobe),
    .out_granted      (out_granted),
    .out_expert_index (out_expert_index),
    .out_worker_index (out_worker_index),
    .out_clipped      (out_clipped),
    .out_last         (out_last)
  );

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the expert capacity limiter: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
  import ecl_pkg::*;

  // A request either loads the capacity of the next expert or proposes a token count.
  typedef enum logic {
    REQ_LOAD    = 1'b0,
    REQ_PROPOSE = 1'b1
  } req_mode_e;

  // Register indexes that the block does not decode. Writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // One grant as the result ports show it.
  typedef struct packed {
    logic [AMOUNT_W-1:0] granted;
    logic [INDEX_W-1:0]  expert_index;
    logic [INDEX_W-1:0]  worker_index;
    logic                clipped;
    logic                last;
  } grant_t;

  // A line of the directed table is either a register write or a request. A request line
  // may carry its grant typed in by hand; the others take the grant from the predictor.
  typedef enum logic {
    ROW_CFG,
    ROW_REQ
  } row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [REG_W-1:0]    reg_value;
    req_mode_e           mode;
    logic [AMOUNT_W-1:0] amount;
    bit                  typed;
    grant_t              grant;
  } table_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_mode = 1'b0;
  logic [AMOUNT_W-1:0]  in_amount = '0;
  logic                 out_strobe;
  logic [AMOUNT_W-1:0]  out_granted;
  logic [INDEX_W-1:0]   out_expert_index;
  logic [INDEX_W-1:0]   out_worker_index;
  logic                 out_clipped;
  logic                 out_last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_wdata = '0;

  expert_capacity_limiter i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_amount        (in_amount),
    .out_strobe       (out_strobe),
    .out_granted      (out_granted),
    .out_expert_index (out_expert_index),
    .out_worker_index (out_worker_index),
    .out_clipped      (out_clipped),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: our own copy of the capacity table, its counters and the registers.
  // The loaded flags keep the stimulus away from table entries that were never written.
  logic [AMOUNT_W-1:0] capacity_left [MAX_EXPERTS];
  bit                  loaded [MAX_EXPERTS];
  int                  load_ptr;
  int                  expert_ptr;
  int                  worker_ptr;
  logic [REG_W-1:0]    experts_reg;
  logic [REG_W-1:0]    workers_reg;

  // Grants that the block still owes us, oldest first.
  grant_t pending_grants [$];

  table_row_t directed_rows [$];

  int errors = 0;
  int loads_sent = 0;
  int proposals_sent = 0;
  int grants_seen = 0;
  int clipped_seen = 0;
  int batches_seen = 0;
  int settings_used = 0;

  // Sender idling: percentage of request slots that start with a gap, and the number of
  // requests left in the current stretch that goes back to back.
  int idle_pct = 0;
  int quiet_left = 0;

  // A register value of zero acts as one; anything above the maximum acts as the maximum.
  function automatic int active_count(input logic [REG_W-1:0] value, input int max_count);
    if (value == 0) return 1;
    if (int'(value) > max_count) return max_count;
    return int'(value);
  endfunction

  // Register write as the block sees it. A decoded write restarts all three counters;
  // the table itself is kept.
  function automatic void apply_register(input logic [CFG_IDX_W-1:0] index,
                                         input logic [REG_W-1:0] value);
    if (index == REG_EXPERTS_IN_USE) begin
      experts_reg = value;
    end else if (index == REG_WORKERS_IN_USE) begin
      workers_reg = value;
    end else begin
      return;
    end
    load_ptr = 0;
    expert_ptr = 0;
    worker_ptr = 0;
  endfunction

  // Works out what one accepted request does. A load writes the table, steps the load
  // counter and returns 0. A proposal gets the smaller of its amount and the capacity left,
  // lowers that capacity, steps the expert and worker counters and returns 1 with the grant.
  function automatic bit admit_tokens(input req_mode_e mode, input logic [AMOUNT_W-1:0] amount,
                                      output grant_t grant);
    int ne;
    int nw;
    int e;
    int w;
    logic [AMOUNT_W-1:0] cap;
    ne = active_count(experts_reg, MAX_EXPERTS);
    nw = active_count(workers_reg, MAX_WORKERS);
    grant = '0;
    // A register may have shrunk the table, so counters beyond it start over.
    if (load_ptr >= ne) load_ptr = 0;
    if (expert_ptr >= ne) expert_ptr = 0;
    if (worker_ptr >= nw) worker_ptr = 0;
    if (mode == REQ_LOAD) begin
      capacity_left[load_ptr] = amount;
      loaded[load_ptr] = 1'b1;
      load_ptr = (load_ptr + 1 >= ne) ? 0 : load_ptr + 1;
      return 1'b0;
    end
    e = expert_ptr;
    w = worker_ptr;
    cap = capacity_left[e];
    grant.clipped = amount > cap;
    grant.granted = grant.clipped ? cap : amount;
    grant.expert_index = INDEX_W'(e);
    grant.worker_index = INDEX_W'(w);
    grant.last = (e == ne - 1) && (w == nw - 1);
    // The capacity holds at zero once exhausted.
    capacity_left[e] = cap - grant.granted;
    expert_ptr = e + 1;
    if (expert_ptr >= ne) begin
      expert_ptr = 0;
      worker_ptr = (w + 1 >= nw) ? 0 : w + 1;
    end
    return 1'b1;
  endfunction

  // Amounts spread over the corners: zero, all ones, small counts that make capacities run
  // out within a batch, and full-width random values.
  function automatic logic [AMOUNT_W-1:0] draw_amount();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      3, 4:    return $urandom_range(0, 64);
      5, 6:    return $urandom_range(0, 2000);
      default: return 32'hFFFF_FFFF - $urandom_range(0, 3);
    endcase
  endfunction

  function automatic table_row_t cfg_row(input logic [CFG_IDX_W-1:0] index,
                                         input logic [REG_W-1:0] value);
    table_row_t row;
    row = '{kind: ROW_CFG, reg_index: index, reg_value: value, mode: REQ_LOAD,
            amount: '0, typed: 1'b0, grant: '0};
    return row;
  endfunction

  function automatic table_row_t req_row(input req_mode_e mode,
                                         input logic [AMOUNT_W-1:0] amount);
    table_row_t row;
    row = '{kind: ROW_REQ, reg_index: '0, reg_value: '0, mode: mode,
            amount: amount, typed: 1'b0, grant: '0};
    return row;
  endfunction

  // A proposal with its grant written out: granted, expert, worker, clipped, last.
  function automatic table_row_t typed_row(input logic [AMOUNT_W-1:0] amount,
                                           input logic [AMOUNT_W-1:0] granted,
                                           input int e, input int w,
                                           input bit clipped, input bit last);
    table_row_t row;
    row = req_row(REQ_PROPOSE, amount);
    row.typed = 1'b1;
    row.grant = '{granted: granted, expert_index: INDEX_W'(e), worker_index: INDEX_W'(w),
                  clipped: clipped, last: last};
    return row;
  endfunction

  // Drives one request and holds it until the block takes it. Before the request the
  // sender may sit idle, which also lands gaps on the busy cycle of a proposal. The call
  // returns at the edge that accepted the request.
  task automatic send_request(input req_mode_e mode, input logic [AMOUNT_W-1:0] amount,
                              input bit typed, input grant_t typed_grant);
    int gap;
    grant_t grant;
    gap = 0;
    if (quiet_left > 0) begin
      quiet_left--;
    end else if ($urandom_range(0, 49) == 0) begin
      quiet_left = 20;
    end else begin
      while (gap < 20 && $urandom_range(0, 99) < idle_pct) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_amount <= amount;
    do @(posedge clk); while (busy);
    if (admit_tokens(mode, amount, grant)) begin
      pending_grants.push_back(typed ? typed_grant : grant);
      proposals_sent++;
    end else begin
      loads_sent++;
    end
  endtask

  // Registers are written only with the block idle: no grant outstanding, then a further
  // wait so that a load or a proposal in flight has finished.
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [REG_W-1:0] value);
    start <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_register(index, value);
    settings_used++;
  endtask

  // Result checker. Results cannot be held off, so every strobe is one grant that must
  // match the oldest prediction field by field.
  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_strobe) begin
      if (pending_grants.size() == 0) begin
        errors++;
        $display("%0t: grant with none expected: granted %0d expert %0d worker %0d",
                 $time, out_granted, out_expert_index, out_worker_index);
      end else begin
        want = pending_grants.pop_front();
        grants_seen++;
        if (out_clipped) clipped_seen++;
        if (out_last) batches_seen++;
        if (out_granted !== want.granted) begin
          errors++;
          $display("%0t: granted expected %0d actual %0d", $time, want.granted, out_granted);
        end
        if (out_expert_index !== want.expert_index) begin
          errors++;
          $display("%0t: expert_index expected %0d actual %0d", $time, want.expert_index,
                   out_expert_index);
        end
        if (out_worker_index !== want.worker_index) begin
          errors++;
          $display("%0t: worker_index expected %0d actual %0d", $time, want.worker_index,
                   out_worker_index);
        end
        if (out_clipped !== want.clipped) begin
          errors++;
          $display("%0t: clipped expected %0b actual %0b", $time, want.clipped, out_clipped);
        end
        if (out_last !== want.last) begin
          errors++;
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_last);
        end
      end
    end
  end

  // Watchdog: far above the slowest legal run of this stimulus.
  initial begin
    #(5_000_000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int phase_experts [12] = '{1, 3, 0, 64, 2, 127, 5, 65, 7, 64, 4, 1};
    int phase_workers [12] = '{1, 2, 5, 2, 64, 0, 3, 64, 1, 64, 127, 9};
    int ne;
    int nw;
    int next_expert;
    int items;
    int drain;

    load_ptr = 0;
    expert_ptr = 0;
    worker_ptr = 0;
    experts_reg = REG_W'(1);
    workers_reg = REG_W'(1);
    foreach (loaded[i]) begin
      loaded[i] = 1'b0;
      capacity_left[i] = '0;
    end

    // Directed part. After reset the block works with one expert and one worker, so every
    // proposal there closes a batch and its grant can be written down directly.
    directed_rows.push_back(req_row(REQ_LOAD, 100));
    directed_rows.push_back(typed_row(40, 40, 0, 0, 1'b0, 1'b1));
    directed_rows.push_back(typed_row(100, 60, 0, 0, 1'b1, 1'b1));
    directed_rows.push_back(typed_row(5, 0, 0, 0, 1'b1, 1'b1));
    directed_rows.push_back(typed_row(0, 0, 0, 0, 1'b0, 1'b1));
    directed_rows.push_back(req_row(REQ_LOAD, 32'hFFFF_FFFF));
    directed_rows.push_back(typed_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1'b0, 1'b1));
    directed_rows.push_back(typed_row(1, 0, 0, 0, 1'b1, 1'b1));
    // Three experts, two workers: the writes restart the load counter at expert 0.
    directed_rows.push_back(cfg_row(REG_EXPERTS_IN_USE, 7'd3));
    directed_rows.push_back(cfg_row(REG_WORKERS_IN_USE, 7'd2));
    directed_rows.push_back(req_row(REQ_LOAD, 10));
    directed_rows.push_back(req_row(REQ_LOAD, 0));
    directed_rows.push_back(req_row(REQ_LOAD, 32'hFFFF_FFFF));
    directed_rows.push_back(typed_row(4, 4, 0, 0, 1'b0, 1'b0));
    directed_rows.push_back(typed_row(7, 0, 1, 0, 1'b1, 1'b0));
    directed_rows.push_back(typed_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 2, 0, 1'b0, 1'b0));
    // An undecoded index in the middle of a batch must leave the counters alone. The load
    // that follows lands on expert 0 again, since the load counter wrapped.
    directed_rows.push_back(cfg_row(REG_SPARE_2, 7'h7F));
    directed_rows.push_back(req_row(REQ_LOAD, 50));
    directed_rows.push_back(req_row(REQ_PROPOSE, 60));
    directed_rows.push_back(req_row(REQ_PROPOSE, 0));
    directed_rows.push_back(req_row(REQ_PROPOSE, 1));
    directed_rows.push_back(cfg_row(REG_SPARE_3, 7'h00));
    // Out-of-range register values: zero experts acts as one, 127 workers as the maximum.
    directed_rows.push_back(cfg_row(REG_EXPERTS_IN_USE, 7'd0));
    directed_rows.push_back(cfg_row(REG_WORKERS_IN_USE, 7'h7F));
    directed_rows.push_back(req_row(REQ_PROPOSE, 3));
    directed_rows.push_back(req_row(REQ_LOAD, 32'h8000_0001));
    directed_rows.push_back(req_row(REQ_PROPOSE, 32'h8000_0000));
    directed_rows.push_back(req_row(REQ_PROPOSE, 3));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 22;
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CFG: write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
        default: send_request(directed_rows[i].mode, directed_rows[i].amount,
                              directed_rows[i].typed, directed_rows[i].grant);
      endcase
    end

    // Random part. Each phase sets both registers in either order, fills the table in use,
    // then runs proposals with random content, with a few loads mixed in as noise and now
    // and then a register rewrite that restarts the batch halfway. The sender idles at 22
    // percent for the first four phases, 59 percent for the next four, then not at all.
    for (int ph = 0; ph < 12; ph++) begin
      idle_pct = (ph < 4) ? 22 : (ph < 8) ? 59 : 0;
      if ($urandom_range(0, 1)) begin
        write_register(REG_EXPERTS_IN_USE, REG_W'(phase_experts[ph]));
        write_register(REG_WORKERS_IN_USE, REG_W'(phase_workers[ph]));
      end else begin
        write_register(REG_WORKERS_IN_USE, REG_W'(phase_workers[ph]));
        write_register(REG_EXPERTS_IN_USE, REG_W'(phase_experts[ph]));
      end
      if ($urandom_range(0, 3) == 0) begin
        write_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, REG_W'($urandom));
      end
      ne = active_count(experts_reg, MAX_EXPERTS);
      nw = active_count(workers_reg, MAX_WORKERS);
      for (int i = 0; i < ne; i++) send_request(REQ_LOAD, draw_amount(), 1'b0, '0);

      // Small settings get requests for at least one batch; larger ones for only part of it.
      items = (ne * nw <= 200 && ne * nw + 12 > 100) ? ne * nw + 12 : 100;
      for (int i = 0; i < items; i++) begin
        next_expert = (expert_ptr >= ne) ? 0 : expert_ptr;
        if (!loaded[next_expert] || $urandom_range(0, 99) < 12) begin
          send_request(REQ_LOAD, draw_amount(), 1'b0, '0);
        end else begin
          send_request(REQ_PROPOSE, draw_amount(), 1'b0, '0);
        end
        if ($urandom_range(0, 299) == 0) write_register(REG_EXPERTS_IN_USE, experts_reg);
      end
    end

    // Let the last grants come home, but not forever.
    start <= 1'b0;
    drain = 0;
    while (pending_grants.size() != 0 && drain < 200) begin
      @(posedge clk);
      drain++;
    end
    if (pending_grants.size() != 0) begin
      errors += pending_grants.size();
      $display("%0t: %0d grants expected but never seen", $time, pending_grants.size());
    end
    repeat (10) @(posedge clk);

    $display("Sent %0d loads and %0d proposals over %0d register writes.", loads_sent,
             proposals_sent, settings_used);
    $display("Checked %0d grants: %0d clipped, %0d closing a batch; %0d mismatches.",
             grants_seen, clipped_seen, batches_seen, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
